// File: rtl/eod_pkg.sv
// Package for the energy onset detector: widths, limits, register indexes
// and the command/status structs between controller and datapath.
// No dependencies.
package eod_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int LEN_W       = 11;
    localparam int THR_W       = 15;
    localparam int ONSET_W     = 12;
    localparam int SHARP_W     = 16;

    localparam int MAX_SAMPLES = 4096;
    localparam int SCNT_W      = $clog2(MAX_SAMPLES + 1);
    localparam int WIN_W       = SCNT_W;

    localparam int LEN_MIN     = 16;
    localparam int LEN_MAX     = 1024;
    localparam int WCNT_W      = $clog2(LEN_MAX);

    localparam int SQ_W        = 2 * SAMPLE_W;
    localparam int SUM_W       = 41;
    localparam int QUO_W       = 37;
    localparam int ROOT_W      = QUO_W + 1;
    localparam int RMS_W       = (QUO_W + 1) / 2;
    localparam int PROD_W      = ONSET_W + LEN_W;
    localparam int SHX_W       = RMS_W + 4;

    localparam int DIV_STEPS   = SUM_W;
    localparam int SQRT_STEPS  = RMS_W;
    localparam int ITER_W      = $clog2(DIV_STEPS);

    localparam int SHARP_MAX   = 32768;
    localparam int LEN_RESET   = 240;
    localparam int THR_RESET   = 328;

    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 15;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CONF_THRESHOLD  = 2'd1;

    typedef struct packed {
        logic load_sq;
        logic accumulate;
        logic div_step;
        logic sqrt_start;
        logic sqrt_step;
        logic update_best;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic window_close;
    } dp_status_t;

endpackage

// File: rtl/eod_if.sv
// Stream interfaces of the energy onset detector: sample words, result
// words and configuration writes. Depends on eod_pkg.
interface eod_in_if;
    logic                              valid;
    logic                              ready;
    logic signed [eod_pkg::SAMPLE_W-1:0] sample;
    logic                              last;

    modport source (output valid, output sample, output last, input ready);
    modport sink   (input valid, input sample, input last, output ready);
endinterface

interface eod_out_if;
    logic                          valid;
    logic                          ready;
    logic [eod_pkg::ONSET_W-1:0]   onset_index;
    logic [eod_pkg::SHARP_W-1:0]   sharpness;
    logic                          confident;

    modport source (output valid, output onset_index, output sharpness,
                    output confident, input ready);
    modport sink   (input valid, input onset_index, input sharpness,
                    input confident, output ready);
endinterface

interface eod_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [eod_pkg::CFG_IDX_W-1:0]   index;
    logic [eod_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/eod_ctrl.sv
// Controller state machine: input/output handshakes, window-close
// sequencing of divider and square root iterations. Depends on eod_pkg.
module eod_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_last,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  eod_pkg::dp_status_t status,
    output eod_pkg::dp_cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_ACC,
        S_ADD,
        S_DIV,
        S_SQINIT,
        S_SQRT,
        S_CMP,
        S_FIN
    } state_t;

    state_t                      state_reg, state_next;
    logic [eod_pkg::ITER_W-1:0]  iter_reg, iter_next;
    logic                        last_reg, last_next;
    logic                        out_valid_reg, out_valid_next;
    logic                        out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_ACC);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        iter_next      = iter_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        unique case (state_reg)
            S_ACC:
            begin
                if (in_valid)
                begin
                    cmd.load_sq = 1'b1;
                    last_next   = in_last;
                    state_next  = S_ADD;
                end
            end
            S_ADD:
            begin
                cmd.accumulate = 1'b1;
                iter_next      = '0;
                if (status.window_close)
                    state_next = S_DIV;
                else if (last_reg)
                    state_next = S_FIN;
                else
                    state_next = S_ACC;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                iter_next    = iter_reg + 1'b1;
                if (iter_reg == eod_pkg::ITER_W'(eod_pkg::DIV_STEPS - 1))
                    state_next = S_SQINIT;
            end
            S_SQINIT:
            begin
                cmd.sqrt_start = 1'b1;
                iter_next      = '0;
                state_next     = S_SQRT;
            end
            S_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                iter_next     = iter_reg + 1'b1;
                if (iter_reg == eod_pkg::ITER_W'(eod_pkg::SQRT_STEPS - 1))
                    state_next = S_CMP;
            end
            S_CMP:
            begin
                cmd.update_best = 1'b1;
                state_next      = last_reg ? S_FIN : S_ACC;
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_ACC;
                end
            end
            default:
            begin
                state_next = S_ACC;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_ACC;
            iter_reg      <= '0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            iter_reg      <= iter_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: rtl/eod_dp.sv
// Datapath: configuration registers, square and accumulate, restoring
// divider, bit-pair square root, rise tracking and result words.
// Depends on eod_pkg.
module eod_dp
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    input  logic [eod_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [eod_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic signed [eod_pkg::SAMPLE_W-1:0]   in_sample,
    input  eod_pkg::dp_cmd_t                      cmd,
    output eod_pkg::dp_status_t                   status,
    output logic [eod_pkg::ONSET_W-1:0]           onset_index,
    output logic [eod_pkg::SHARP_W-1:0]           sharpness,
    output logic                                  confident
);

    logic [eod_pkg::LEN_W-1:0]   wl_reg;
    logic [eod_pkg::THR_W-1:0]   thr_reg;
    logic [eod_pkg::LEN_W-1:0]   len;

    logic [eod_pkg::SQ_W-1:0]    sq_reg;
    logic [eod_pkg::SUM_W-1:0]   sum_reg;
    logic [eod_pkg::SUM_W-1:0]   sum_next;
    logic [eod_pkg::WCNT_W-1:0]  wcnt_reg;
    logic [eod_pkg::SCNT_W-1:0]  scnt_reg;
    logic [eod_pkg::WIN_W-1:0]   win_reg;
    logic [eod_pkg::RMS_W-1:0]   prev_reg;
    logic                        havep_reg;
    logic [eod_pkg::RMS_W-1:0]   brise_reg;
    logic [eod_pkg::WIN_W-1:0]   bidx_reg;

    logic [eod_pkg::SUM_W-1:0]   dvd_reg;
    logic [eod_pkg::LEN_W-1:0]   rem_reg;
    logic [eod_pkg::LEN_W:0]     div_try;
    logic                        div_ge;
    logic [eod_pkg::LEN_W:0]     div_diff;

    logic [eod_pkg::QUO_W-1:0]   v_reg;
    logic [eod_pkg::ROOT_W-1:0]  root_reg;
    logic [eod_pkg::QUO_W-1:0]   bit_reg;
    logic [eod_pkg::ROOT_W-1:0]  sq_try;
    logic                        sq_ge;

    logic [eod_pkg::RMS_W-1:0]   rms;
    logic [eod_pkg::RMS_W-1:0]   rise;
    logic                        sample_ok;
    logic [eod_pkg::LEN_W-1:0]   wcnt_inc;

    logic [eod_pkg::PROD_W-1:0]  onset_prod;
    logic [eod_pkg::SHX_W-1:0]   sharp_x10;

    logic [eod_pkg::ONSET_W-1:0] onset_reg;
    logic [eod_pkg::SHARP_W-1:0] sharp_reg;
    logic                        conf_reg;

    always_comb
    begin
        if (wl_reg < eod_pkg::LEN_W'(eod_pkg::LEN_MIN))
            len = eod_pkg::LEN_W'(eod_pkg::LEN_MIN);
        else if (wl_reg > eod_pkg::LEN_W'(eod_pkg::LEN_MAX))
            len = eod_pkg::LEN_W'(eod_pkg::LEN_MAX);
        else
            len = wl_reg;
    end

    assign sample_ok           = scnt_reg < eod_pkg::SCNT_W'(eod_pkg::MAX_SAMPLES);
    assign wcnt_inc            = eod_pkg::LEN_W'(wcnt_reg) + 1'b1;
    assign status.window_close = sample_ok && (wcnt_inc >= len);
    assign sum_next            = sum_reg + eod_pkg::SUM_W'(sq_reg);

    assign div_try  = {rem_reg, dvd_reg[eod_pkg::SUM_W-1]};
    assign div_ge   = div_try >= {1'b0, len};
    assign div_diff = div_try - {1'b0, len};

    assign sq_try = root_reg + {1'b0, bit_reg};
    assign sq_ge  = {1'b0, v_reg} >= sq_try;

    assign rms  = root_reg[eod_pkg::RMS_W-1:0];
    assign rise = rms - prev_reg;

    assign onset_prod = eod_pkg::PROD_W'(bidx_reg[eod_pkg::ONSET_W-1:0])
                        * eod_pkg::PROD_W'(len);
    assign sharp_x10  = (eod_pkg::SHX_W'(brise_reg) << 3)
                        + (eod_pkg::SHX_W'(brise_reg) << 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wl_reg  <= eod_pkg::LEN_W'(eod_pkg::LEN_RESET);
            thr_reg <= eod_pkg::THR_W'(eod_pkg::THR_RESET);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                eod_pkg::REG_WINDOW_LENGTH:
                    wl_reg <= cfg_data[eod_pkg::LEN_W-1:0];
                eod_pkg::REG_CONF_THRESHOLD:
                    thr_reg <= cfg_data[eod_pkg::THR_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            wcnt_reg  <= '0;
            scnt_reg  <= '0;
            win_reg   <= '0;
            prev_reg  <= '0;
            havep_reg <= 1'b0;
            brise_reg <= '0;
            bidx_reg  <= '0;
        end
        else if (cmd.finish)
        begin
            sum_reg   <= '0;
            wcnt_reg  <= '0;
            scnt_reg  <= '0;
            win_reg   <= '0;
            prev_reg  <= '0;
            havep_reg <= 1'b0;
            brise_reg <= '0;
            bidx_reg  <= '0;
        end
        else if (cmd.accumulate && sample_ok)
        begin
            scnt_reg <= scnt_reg + 1'b1;
            if (status.window_close)
            begin
                sum_reg  <= '0;
                wcnt_reg <= '0;
            end
            else
            begin
                sum_reg  <= sum_next;
                wcnt_reg <= wcnt_inc[eod_pkg::WCNT_W-1:0];
            end
        end
        else if (cmd.update_best)
        begin
            if (havep_reg && (rms > prev_reg) && (rise > brise_reg))
            begin
                brise_reg <= rise;
                bidx_reg  <= win_reg - 1'b1;
            end
            prev_reg  <= rms;
            havep_reg <= 1'b1;
            win_reg   <= win_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_sq)
            sq_reg <= eod_pkg::SQ_W'(in_sample * in_sample);

        if (cmd.accumulate)
        begin
            dvd_reg <= sum_next;
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            dvd_reg <= {dvd_reg[eod_pkg::SUM_W-2:0], div_ge};
            rem_reg <= div_ge ? div_diff[eod_pkg::LEN_W-1:0]
                              : div_try[eod_pkg::LEN_W-1:0];
        end

        if (cmd.sqrt_start)
        begin
            v_reg    <= dvd_reg[eod_pkg::QUO_W-1:0];
            root_reg <= '0;
            bit_reg  <= eod_pkg::QUO_W'(1) << (eod_pkg::QUO_W - 1);
        end
        else if (cmd.sqrt_step)
        begin
            if (sq_ge)
            begin
                v_reg    <= v_reg - sq_try[eod_pkg::QUO_W-1:0];
                root_reg <= (root_reg >> 1) + {1'b0, bit_reg};
            end
            else
            begin
                root_reg <= root_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end

        if (cmd.finish)
        begin
            onset_reg <= onset_prod[eod_pkg::ONSET_W-1:0];
            if (sharp_x10 > eod_pkg::SHX_W'(eod_pkg::SHARP_MAX))
                sharp_reg <= eod_pkg::SHARP_W'(eod_pkg::SHARP_MAX);
            else
                sharp_reg <= sharp_x10[eod_pkg::SHARP_W-1:0];
            conf_reg  <= brise_reg > eod_pkg::RMS_W'(thr_reg);
        end
    end

    assign onset_index = onset_reg;
    assign sharpness   = sharp_reg;
    assign confident   = conf_reg;

endmodule

// File: rtl/energy_onset_detector_top.sv
// Energy onset detector top: a sample word is taken only when the previous
// one is through; a word that closes a window first runs the 41-step
// divider, the square root and a compare. A finish state follows the last
// word; the output register lets a new buffer start while a result waits.
// Reset clears all buffer state at once; registers return to 240 and 328.
module energy_onset_detector_top
(
    input  logic           clk,
    input  logic           rst_n,
    eod_in_if.sink         samples,
    eod_out_if.source      results,
    eod_cfg_if.sink        cfg
);

    eod_pkg::dp_cmd_t    cmd;
    eod_pkg::dp_status_t status;

    assign cfg.ready = 1'b1;

    eod_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (samples.valid),
        .in_last   (samples.last),
        .in_ready  (samples.ready),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .status    (status),
        .cmd       (cmd)
    );

    eod_dp u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg.valid),
        .cfg_index   (cfg.index),
        .cfg_data    (cfg.data),
        .in_sample   (samples.sample),
        .cmd         (cmd),
        .status      (status),
        .onset_index (results.onset_index),
        .sharpness   (results.sharpness),
        .confident   (results.confident)
    );

endmodule

// File: test/eod_checker.sv
// Checker for the energy onset detector: watches the sample, result and register
// channels, predicts each buffer's onset word and compares it with the block's.
// Depends on eod_pkg and the stream interfaces in eod_if.
module eod_checker
    import eod_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    eod_in_if    samples,
    eod_out_if   results,
    eod_cfg_if   cfg,
    output int   mismatches,
    output int   waiting,
    output int   words_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [ONSET_W-1:0] onset_index;
        logic [SHARP_W-1:0] sharpness;
        logic               confident;
    } onset_word_t;

    onset_word_t        pending_onsets[$];

    logic [LEN_W-1:0]   window_length;
    logic [THR_W-1:0]   threshold;

    logic [SUM_W-1:0]   square_sum;
    logic [LEN_W-1:0]   in_window;
    logic [SCNT_W-1:0]  sample_count;
    logic [WIN_W-1:0]   window_index;
    logic [16:0]        previous_rms;
    logic               have_previous;
    logic [16:0]        best_rise;
    logic [WIN_W-1:0]   best_index;

    int                 mismatch_count;
    int                 checked_count;

    function automatic logic [LEN_W-1:0] clamp_length(input logic [LEN_W-1:0] raw);
        if (raw < LEN_W'(LEN_MIN))
            return LEN_W'(LEN_MIN);
        if (raw > LEN_W'(LEN_MAX))
            return LEN_W'(LEN_MAX);
        return raw;
    endfunction

    function automatic logic [16:0] floor_root(input logic [SUM_W-1:0] value);
        logic [16:0] root;
        logic [16:0] trial;
        root = '0;
        for (int b = 16; b >= 0; b--)
        begin
            trial = root | (17'd1 << b);
            if (longint'(trial) * longint'(trial) <= longint'(value))
                root = trial;
        end
        return root;
    endfunction

    task automatic clear_buffer();
        square_sum    = '0;
        in_window     = '0;
        sample_count  = '0;
        window_index  = '0;
        previous_rms  = '0;
        have_previous = 1'b0;
        best_rise     = '0;
        best_index    = '0;
    endtask

    task automatic track_energy(input logic signed [SAMPLE_W-1:0] value,
                                input logic closing);
        logic [LEN_W-1:0]        len;
        logic signed [SQ_W-1:0]  square;
        logic [SUM_W-1:0]        quotient;
        logic [16:0]             rms;
        logic [16:0]             rise;
        logic [WIN_W+LEN_W-1:0]  product;
        logic [20:0]             tenfold;
        onset_word_t             word;
        len = clamp_length(window_length);
        if (sample_count < MAX_SAMPLES)
        begin
            square       = value * value;
            square_sum   = square_sum + {{(SUM_W-SQ_W){1'b0}}, square};
            in_window    = in_window + 1'b1;
            sample_count = sample_count + 1'b1;
            if (in_window >= len)
            begin
                quotient = square_sum / {{(SUM_W-LEN_W){1'b0}}, len};
                rms      = floor_root(quotient);
                if (have_previous && rms > previous_rms)
                begin
                    rise = rms - previous_rms;
                    if (rise > best_rise)
                    begin
                        best_rise  = rise;
                        best_index = window_index - 1'b1;
                    end
                end
                previous_rms  = rms;
                have_previous = 1'b1;
                window_index  = window_index + 1'b1;
                square_sum    = '0;
                in_window     = '0;
            end
        end
        if (closing)
        begin
            product          = best_index * len;
            tenfold          = best_rise * 21'd10;
            word.onset_index = product[ONSET_W-1:0];
            word.sharpness   = (tenfold > SHARP_MAX) ? SHARP_W'(SHARP_MAX)
                                                     : tenfold[SHARP_W-1:0];
            word.confident   = best_rise > {2'b00, threshold};
            pending_onsets.push_back(word);
            clear_buffer();
        end
    endtask

    task automatic compare_onset();
        onset_word_t got;
        onset_word_t want;
        got = '{results.onset_index, results.sharpness, results.confident};
        checked_count++;
        if (pending_onsets.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("unexpected result word: onset %0d sharp %0d conf %0b",
                         got.onset_index, got.sharpness, got.confident);
        end
        else
        begin
            want = pending_onsets.pop_front();
            if (want != got)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("expected onset %0d sharp %0d conf %0b, got %0d %0d %0b",
                             want.onset_index, want.sharpness, want.confident,
                             got.onset_index, got.sharpness, got.confident);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_length  = LEN_W'(LEN_RESET);
            threshold      = THR_W'(THR_RESET);
            clear_buffer();
            pending_onsets.delete();
            mismatch_count = 0;
            checked_count  = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == REG_WINDOW_LENGTH)
                    window_length = cfg.data[LEN_W-1:0];
                else if (cfg.index == REG_CONF_THRESHOLD)
                    threshold = cfg.data[THR_W-1:0];
            end
            if (samples.valid && samples.ready)
                track_energy(samples.sample, samples.last);
            if (results.valid && results.ready)
                compare_onset();
        end
        mismatches    = mismatch_count;
        waiting       = pending_onsets.size();
        words_checked = checked_count;
    end

endmodule

// File: test/testbench.sv
// Top of the energy onset detector test: clock, reset, sample buffers and
// register writes, with random pacing on both streams; the checker judges results.
// Depends on eod_pkg, eod_if, energy_onset_detector_top and eod_checker.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import eod_pkg::*;

    localparam int SETTLE_CYCLES = 100;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    typedef enum int {TONE_SILENT, TONE_NOISE, TONE_SCALED, TONE_PEAK, TONE_FLAT} tone_t;

    logic clk;
    logic rst_n;

    eod_in_if  sample_ch();
    eod_out_if result_ch();
    eod_cfg_if cfg_ch();

    int mismatches;
    int waiting;
    int words_checked;

    bit steady_source;
    bit steady_sink;
    int stall_left;

    logic signed [SAMPLE_W-1:0] pcm_q[$];
    int buffers_sent;
    int words_sent;
    int reg_writes;

    energy_onset_detector_top dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (sample_ch),
        .results (result_ch),
        .cfg     (cfg_ch)
    );

    eod_checker onset_check
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .samples       (sample_ch),
        .results       (result_ch),
        .cfg           (cfg_ch),
        .mismatches    (mismatches),
        .waiting       (waiting),
        .words_checked (words_checked)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    initial
    begin
        #100_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    always @(negedge clk)
    begin : sink_pacing
        int roll;
        roll = $urandom_range(0, 99);
        if (!rst_n)
            result_ch.ready <= 1'b0;
        else if (steady_sink)
            result_ch.ready <= 1'b1;
        else if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            result_ch.ready <= 1'b0;
        end
        else if (roll < 70)
            result_ch.ready <= 1'b1;
        else
        begin
            stall_left = (roll < 93) ? $urandom_range(0, 2) : $urandom_range(7, 39);
            result_ch.ready <= 1'b0;
        end
    end

    function automatic int gap_length();
        int roll;
        if (steady_source)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 65)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int clamp_length(input int raw);
        if (raw < LEN_MIN)
            return LEN_MIN;
        if (raw > LEN_MAX)
            return LEN_MAX;
        return raw;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] make_word(input tone_t tone,
                                                             input int amp,
                                                             input int level);
        int mag;
        mag = $urandom_range(0, amp);
        case (tone)
            TONE_SILENT: return '0;
            TONE_NOISE:  return SAMPLE_W'($urandom());
            TONE_SCALED: return ($urandom_range(0, 1) != 0) ? SAMPLE_W'(-mag)
                                                            : SAMPLE_W'(mag);
            TONE_PEAK:   return ($urandom_range(0, 1) != 0) ? 16'sh8000 : 16'sh7FFF;
            default:     return SAMPLE_W'(level);
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
        @(negedge clk);
        reg_writes++;
    endtask

    task automatic push_word(input logic signed [SAMPLE_W-1:0] value, input logic closing);
        int gap;
        gap = gap_length();
        if (gap > 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        sample_ch.valid  <= 1'b1;
        sample_ch.sample <= value;
        sample_ch.last   <= closing;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic play_pcm(input logic closed);
        for (int i = 0; i < pcm_q.size(); i++)
            push_word(pcm_q[i], closed && (i == pcm_q.size() - 1));
        sample_ch.valid <= 1'b0;
        @(negedge clk);
        words_sent   += pcm_q.size();
        buffers_sent += closed;
        pcm_q.delete();
    endtask

    task automatic drain();
        while (waiting != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic fill_const(input logic signed [SAMPLE_W-1:0] value, input int count);
        repeat (count) pcm_q.push_back(value);
    endtask

    // equal rises in windows two and four: the earlier one must win
    task automatic stage_tie_pattern();
        fill_const(16'sd0, 16);
        fill_const(16'sd0, 16);
        fill_const(16'sd1000, 16);
        fill_const(16'sd0, 16);
        fill_const(16'sd1000, 16);
    endtask

    task automatic build_random_pcm(input int len);
        int    kind;
        int    windows;
        int    partial;
        int    amp;
        int    level;
        tone_t tone;
        kind = $urandom_range(0, 9);
        if (kind < 2 || len > 160)
        begin
            repeat ($urandom_range(1, 12)) pcm_q.push_back(make_word(TONE_NOISE, 0, 0));
        end
        else
        begin
            windows = (len <= 24) ? $urandom_range(1, 7) : $urandom_range(1, 3);
            partial = ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(1, len - 1);
            for (int w = 0; w <= windows; w++)
            begin
                tone  = tone_t'($urandom_range(0, 4));
                amp   = $urandom_range(0, 32767);
                level = $urandom_range(0, 65535) - 32768;
                repeat ((w < windows) ? len : partial)
                    pcm_q.push_back(make_word(tone, amp, level));
            end
        end
    endtask

    initial
    begin : stimulus
        int               pick;
        int               raw_len;
        int               random_words;
        int               random_buffers;
        logic [3:0]       pad;
        logic [THR_W-1:0] thr;

        rst_n            = 1'b0;
        sample_ch.valid  = 1'b0;
        sample_ch.sample = '0;
        sample_ch.last   = 1'b0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.index     = '0;
        cfg_ch.data      = '0;
        steady_source    = 1'b0;
        steady_sink      = 1'b0;
        buffers_sent     = 0;
        words_sent       = 0;
        reg_writes       = 0;
        random_words     = 0;
        random_buffers   = 0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset lengths, no full window
        pcm_q.push_back(16'sh8000);
        pcm_q.push_back(16'sh7FFF);
        pcm_q.push_back(16'sh0000);
        play_pcm(1'b1);
        drain();

        // upper data bits must be masked off the window length
        write_reg(REG_WINDOW_LENGTH, 15'h7810);
        write_reg(REG_CONF_THRESHOLD, 15'h0000);
        fill_const(16'sd0, 16);
        fill_const(16'sh8000, 16);
        fill_const(16'sh7FFF, 5);
        play_pcm(1'b1);
        stage_tie_pattern();
        play_pcm(1'b1);
        drain();

        write_reg(REG_CONF_THRESHOLD, 15'h7FFF);
        write_reg(REG_SPARE_2, 15'h0100);
        write_reg(REG_SPARE_3, 15'h7FFF);
        fill_const(16'sd0, 16);
        fill_const(16'sh8000, 16);
        play_pcm(1'b1);
        fill_const(16'sd2000, 16);
        fill_const(16'sd1000, 16);
        fill_const(16'sd0, 16);
        play_pcm(1'b1);
        drain();

        write_reg(REG_WINDOW_LENGTH, 15'd0);
        write_reg(REG_CONF_THRESHOLD, 15'd1000);
        stage_tie_pattern();
        play_pcm(1'b1);
        drain();
        write_reg(REG_CONF_THRESHOLD, 15'd999);
        stage_tie_pattern();
        play_pcm(1'b1);
        drain();

        // widen the window mid-buffer so the onset product wraps
        fill_const(16'sd100, 8 * 16);
        fill_const(16'sd20000, 16);
        play_pcm(1'b0);
        drain();
        write_reg(REG_WINDOW_LENGTH, 15'd1024);
        pcm_q.push_back(16'sd0);
        play_pcm(1'b1);
        drain();

        // overlong buffer: loud samples past the limit must be dropped
        write_reg(REG_WINDOW_LENGTH, 15'd16);
        for (int i = 0; i < MAX_SAMPLES + 20; i++)
        begin
            if (i < MAX_SAMPLES)
                pcm_q.push_back(make_word(TONE_SCALED, ((i / 16) * 37) % 5000, 0));
            else
                pcm_q.push_back(16'sh8000);
        end
        play_pcm(1'b1);
        drain();

        while (random_words < 1400 || random_buffers < 48)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 12)
                raw_len = $urandom_range(16, 24);
            else if (pick < 15)
                raw_len = $urandom_range(25, 64);
            else if (pick < 17)
                raw_len = $urandom_range(0, 15);
            else if (pick < 18)
                raw_len = $urandom_range(1025, 2047);
            else
                raw_len = $urandom_range(65, 160);
            pad  = $urandom_range(0, 15);
            pick = $urandom_range(0, 9);
            if (pick == 0)
                thr = '0;
            else if (pick == 1)
                thr = '1;
            else if (pick < 5)
                thr = THR_W'($urandom());
            else
                thr = THR_W'($urandom_range(0, 4000));
            if ($urandom_range(0, 1) != 0)
            begin
                write_reg(REG_WINDOW_LENGTH, {pad, LEN_W'(raw_len)});
                write_reg(REG_CONF_THRESHOLD, thr);
            end
            else
            begin
                write_reg(REG_CONF_THRESHOLD, thr);
                write_reg(REG_WINDOW_LENGTH, {pad, LEN_W'(raw_len)});
            end
            steady_source = ($urandom_range(0, 4) == 0);
            steady_sink   = ($urandom_range(0, 4) == 0);
            repeat ($urandom_range(1, 4))
            begin
                build_random_pcm(clamp_length(raw_len));
                random_words += pcm_q.size();
                random_buffers++;
                play_pcm(1'b1);
            end
            drain();
        end

        steady_sink = 1'b0;
        drain();

        $display("Sent %0d buffers, %0d sample words and %0d register writes,",
                 buffers_sent, words_sent, reg_writes);
        $display("window lengths clamped at both ends; %0d result words compared.",
                 words_checked);
        if (mismatches == 0 && waiting == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
